@@ src/lru_writeback_page_cache_tags_unit_macros.svh @@
// Assertion macros for the page cache tag controller.
// Used by lru_writeback_page_cache_tags_unit; expects clk and arst_n in scope.
`ifndef LRU_WRITEBACK_PAGE_CACHE_TAGS_UNIT_MACROS_SVH
`define LRU_WRITEBACK_PAGE_CACHE_TAGS_UNIT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define LRUPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, ignored while in reset
`define LRUPC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/lrupc_pkg.sv @@
// Shared constants for the page cache tag controller.
// No dependencies.
package lrupc_pkg;

	localparam int ID_BITS      = 16;
	localparam int IN_TDATA_W   = 16;
	localparam int IN_TUSER_W   = 1;
	localparam int SLOT_W       = 3;
	localparam int OUT_TDATA_W  = 24;
	localparam int OUT_TUSER_W  = 3;
	localparam int CFG_W        = 4;

	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 4'd8;

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// result flag positions in tuser
	localparam int TU_HIT  = 0;
	localparam int TU_FILL = 1;
	localparam int TU_WB   = 2;

endpackage

@@ src/lru_writeback_page_cache_tags_unit.sv @@
// Tag, dirty and LRU controller of a fully associative write-back page cache.
// Channels: slave stream takes one access item (tuser = op, tdata = page id);
// master stream returns one result item per access (tuser = hit, fill,
// writeback; tdata = slot, evicted id). cfg_we/cfg_wdata write slots_in_use.
// Tags and dirty bits live in one RAM, the recency list (least recent first)
// in another; both are walked one entry a cycle by a small sequencer.
// An item first scans the recency list in order, looking each slot's tag up
// (two RAM reads deep); a hit or an eviction then shifts the tail of the list
// down one entry a cycle and appends the touched slot, while a miss into a
// free slot is appended at the end of the list. s_axis_tready is high only
// while no access is being worked on, so a new item is not taken before the
// last one is through.
// The result sits in an output register: the next item is taken while it
// waits, but that item's result is held back until the receiver takes the
// previous one. Reset empties the cache (occupancy count to zero) and sets
// slots_in_use to 8; RAM contents are not cleared, as only occupied entries
// are ever read.
module lru_writeback_page_cache_tags_unit import lrupc_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] page_id
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [0] op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] slot, [18:3] evicted_id, zero pad
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] hit, [1] fill, [2] writeback
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata       // slots_in_use
);

	`include "lru_writeback_page_cache_tags_unit_macros.svh"

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_FIN} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    slots_q;
	logic [CW-1:0]       used_q;
	logic                op_q;
	logic [ID_BITS-1:0]  id_q;

	// scan pipeline
	logic [CW-1:0]       p_q;
	logic                v_s1, v_s2;
	logic [IW-1:0]       pos_s1, pos_s2, slot_s2;
	logic [IW-1:0]       vic_slot_q;
	logic                vic_dirty_q;
	logic [ID_BITS-1:0]  vic_tag_q;

	// shift pass
	logic [CW-1:0]       sp_q;
	logic                shv_q;
	logic [IW-1:0]       wpos_q;
	logic [IW-1:0]       idx_q;

	// result being built
	logic                hit_q, fill_q, wb_q;
	logic [ID_BITS-1:0]  ev_q;

	// output register
	logic                m_valid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	// RAM ports
	logic                rec_we;
	logic [IW-1:0]       rec_waddr, rec_wdata, rec_raddr, rec_rdata;
	logic                tag_we;
	logic [ID_BITS:0]    tag_wdata, tag_rdata;
	logic [IW-1:0]       tag_waddr;

	logic [CW-1:0]       limit;
	logic                in_acc, match, last, miss_now, hit_now, shift_done;
	logic [IW-1:0]       vic_slot;
	logic                vic_dirty;
	logic [ID_BITS-1:0]  vic_tag;

	lrupc_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	// {dirty, tag}; read address is the slot just read from the recency list
	lrupc_ram #(.WIDTH(ID_BITS + 1), .DEPTH(SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (rec_rdata),
		.rdata (tag_rdata)
	);

	always_comb begin
		if (slots_q == '0) begin
			limit = CW'(1);
		end else if (int'(slots_q) > SLOTS) begin
			limit = CW'(SLOTS);
		end else begin
			limit = CW'(slots_q);
		end
	end

	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign match      = v_s2 && (tag_rdata[ID_BITS-1:0] == id_q);
	assign last       = (CW'(pos_s2) == used_q - CW'(1));
	assign miss_now   = (state_q == ST_SCAN) && ((used_q == '0) || (v_s2 && !match && last));
	assign hit_now    = (state_q == ST_SCAN) && match;
	assign shift_done = (state_q == ST_SHIFT) && (sp_q >= used_q) && !shv_q;

	// LRU victim: recency position 0, taken straight off the RAM when just read
	assign vic_slot  = (v_s2 && pos_s2 == '0) ? slot_s2 : vic_slot_q;
	assign vic_dirty = (v_s2 && pos_s2 == '0) ? tag_rdata[ID_BITS] : vic_dirty_q;
	assign vic_tag   = (v_s2 && pos_s2 == '0) ? tag_rdata[ID_BITS-1:0] : vic_tag_q;

	always_comb begin
		rec_raddr = '0;
		rec_we    = 1'b0;
		rec_waddr = '0;
		rec_wdata = '0;
		tag_we    = 1'b0;
		tag_waddr = '0;
		tag_wdata = {op_q == OP_WRITE, id_q};
		unique case (state_q)
			ST_SCAN: begin
				rec_raddr = p_q[IW-1:0];
				if (miss_now) begin
					tag_we = 1'b1;
					if (used_q < limit) begin
						rec_we    = 1'b1;
						rec_waddr = used_q[IW-1:0];
						rec_wdata = used_q[IW-1:0];
						tag_waddr = used_q[IW-1:0];
					end else begin
						tag_waddr = vic_slot;
					end
				end else if (hit_now && op_q == OP_WRITE) begin
					tag_we    = 1'b1;
					tag_waddr = slot_s2;
				end
			end
			ST_SHIFT: begin
				rec_raddr = sp_q[IW-1:0];
				if (shv_q) begin
					rec_we    = 1'b1;
					rec_waddr = wpos_q;
					rec_wdata = rec_rdata;
				end else if (shift_done) begin
					rec_we    = 1'b1;
					rec_waddr = IW'(used_q - CW'(1));
					rec_wdata = idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slots_q   <= SLOTS_IN_USE_RESET;
			used_q    <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			shv_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			// in ST_FIN the output register is handled below
			if (m_valid_q && m_axis_tready && state_q != ST_FIN) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q    <= s_axis_tuser[0];
						id_q    <= s_axis_tdata[ID_BITS-1:0];
						p_q     <= '0;
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (p_q < used_q) begin
						v_s1   <= 1'b1;
						pos_s1 <= p_q[IW-1:0];
						p_q    <= p_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					v_s2    <= v_s1;
					pos_s2  <= pos_s1;
					slot_s2 <= rec_rdata;
					if (v_s2 && pos_s2 == '0) begin
						vic_slot_q  <= slot_s2;
						vic_dirty_q <= tag_rdata[ID_BITS];
						vic_tag_q   <= tag_rdata[ID_BITS-1:0];
					end
					if (miss_now) begin
						hit_q  <= 1'b0;
						fill_q <= (op_q == OP_READ);
						if (used_q < limit) begin
							idx_q   <= used_q[IW-1:0];
							used_q  <= used_q + CW'(1);
							wb_q    <= 1'b0;
							ev_q    <= '0;
							state_q <= ST_FIN;
						end else begin
							idx_q   <= vic_slot;
							wb_q    <= vic_dirty;
							ev_q    <= vic_dirty ? vic_tag : '0;
							sp_q    <= CW'(1);
							shv_q   <= 1'b0;
							state_q <= ST_SHIFT;
						end
					end else if (hit_now) begin
						hit_q   <= 1'b1;
						fill_q  <= 1'b0;
						wb_q    <= 1'b0;
						ev_q    <= '0;
						idx_q   <= slot_s2;
						sp_q    <= CW'(pos_s2) + CW'(1);
						shv_q   <= 1'b0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// read entry sp, write it one place down in the next cycle
					if (sp_q < used_q) begin
						sp_q   <= sp_q + CW'(1);
						shv_q  <= 1'b1;
						wpos_q <= IW'(sp_q - CW'(1));
					end else begin
						shv_q <= 1'b0;
					end
					if (shift_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_tdata_q <= OUT_TDATA_W'({ev_q, SLOT_W'(idx_q)});
						m_tuser_q <= {wb_q, fill_q, hit_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	`LRUPC_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CW'(SLOTS), "occupancy above slot count")
	`LRUPC_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready, "ready right after accept")
	`LRUPC_ASSERT_IMP(a_hit_no_transfer, m_axis_tvalid && m_axis_tuser[TU_HIT],
		!m_axis_tuser[TU_FILL] && !m_axis_tuser[TU_WB], "hit with fill or writeback")
	`LRUPC_ASSERT_IMP(a_single_decision, 1'b1, !(miss_now && hit_now), "hit and miss together")

endmodule

@@ src/lrupc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lrupc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ tb/lru_writeback_page_cache_tags_unit_tb.sv @@
// Testbench for lru_writeback_page_cache_tags_unit: tag, dirty and LRU behaviour
// checked item by item against an in-bench cache model, with random stalls on both streams.
// Depends on lrupc_pkg and the unit itself.
module lru_writeback_page_cache_tags_unit_tb;
	import lrupc_pkg::*;

	localparam int N_SLOTS       = 8;
	localparam int RUN_LIMIT     = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 130;
	localparam int POOL_SIZE     = 12;

	typedef struct {
		logic                  hit;
		logic [SLOT_W-1:0]     slot;
		logic                  fill;
		logic                  wb;
		logic [ID_BITS-1:0]    evicted;
	} access_result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   cfg_we        = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata     = '0;

	lru_writeback_page_cache_tags_unit #(.SLOTS(N_SLOTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// cache model state
	logic [ID_BITS-1:0] cache_tags  [N_SLOTS];
	logic               cache_dirty [N_SLOTS];
	logic [SLOT_W-1:0]  lru_list    [N_SLOTS];   // least recent first
	int                 occupied       = 0;
	logic [CFG_W-1:0]   slots_setting  = SLOTS_IN_USE_RESET;

	access_result_t     pending_results [$];
	logic [ID_BITS-1:0] page_pool [POOL_SIZE];
	int                 errors       = 0;
	int                 cycles       = 0;
	bit                 quiet        = 1'b0;
	int                 rx_hold_req  = 0;
	int                 rx_hold_left = 0;

	task automatic predict_access(input logic op, input logic [ID_BITS-1:0] id);
		access_result_t r;
		int lim, idx, pos, i;
		r.hit = 1'b0;
		r.fill = 1'b0;
		r.wb = 1'b0;
		r.evicted = '0;
		lim = (slots_setting == 0) ? 1 : (slots_setting > N_SLOTS) ? N_SLOTS : slots_setting;
		idx = -1;
		for (i = 0; i < occupied; i++)
			if (idx < 0 && cache_tags[i] == id)
				idx = i;
		if (idx >= 0) begin
			r.hit = 1'b1;
			pos = 0;
			for (i = occupied - 1; i >= 0; i--)
				if (lru_list[i] == idx)
					pos = i;
			for (i = pos; i < occupied - 1; i++)
				lru_list[i] = lru_list[i + 1];
			lru_list[occupied - 1] = SLOT_W'(idx);
			if (op == OP_WRITE)
				cache_dirty[idx] = 1'b1;
		end else begin
			if (occupied < lim) begin
				idx = occupied;
				lru_list[occupied] = SLOT_W'(idx);
				occupied++;
			end else begin
				// evict the least recent of all occupied slots
				idx = lru_list[0];
				for (i = 0; i < occupied - 1; i++)
					lru_list[i] = lru_list[i + 1];
				lru_list[occupied - 1] = SLOT_W'(idx);
				if (cache_dirty[idx]) begin
					r.wb = 1'b1;
					r.evicted = cache_tags[idx];
				end
			end
			cache_tags[idx] = id;
			cache_dirty[idx] = (op == OP_WRITE);
			r.fill = (op == OP_READ);
		end
		r.slot = SLOT_W'(idx);
		pending_results.push_back(r);
	endtask

	// offer one access item; returns at the edge where it is taken
	task automatic send_access(input logic op, input logic [ID_BITS-1:0] id);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= id;
		do @(posedge clk); while (!s_axis_tready);
		predict_access(op, id);
	endtask

	task automatic wait_idle;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		slots_setting = value;
	endtask

	// zero setting acts as one slot: every miss after the first replaces slot 0
	task automatic test_single_slot;
		write_slots_in_use(4'd0);
		send_access(OP_READ,  16'h0000);
		send_access(OP_WRITE, 16'hFFFF);   // clean victim
		send_access(OP_READ,  16'hFFFF);   // hit, stays dirty
		send_access(OP_WRITE, 16'hA5A5);   // dirty victim, no fill
		send_access(OP_READ,  16'h5A5A);   // dirty victim, fill
	endtask

	// oversized setting acts as all slots
	task automatic test_oversized_setting;
		int i;
		write_slots_in_use(4'd15);
		for (i = 1; i < N_SLOTS; i++)
			send_access((i % 2) ? OP_WRITE : OP_READ, ID_BITS'(i * 16'h1111));
		send_access(OP_WRITE, 16'h2222);   // hit on a clean slot marks it dirty
		send_access(OP_READ,  16'h5A5A);   // hit on the oldest, moves to most recent
		send_access(OP_READ,  16'h8000);   // evicts the next oldest
	endtask

	// setting lowered under occupancy: no new slot, LRU of all occupied goes
	task automatic test_setting_below_occupancy;
		write_slots_in_use(4'd1);
		send_access(OP_WRITE, 16'h0001);
		send_access(OP_READ,  16'h0002);
		send_access(OP_READ,  16'h0001);
		write_slots_in_use(4'd8);
	endtask

	// receiver stalls long while items keep coming, so the input side backs up
	task automatic test_output_backpressure;
		int i;
		wait_idle();
		rx_hold_req = 400;
		for (i = 0; i < 16; i++)
			send_access(1'($urandom_range(1)), ID_BITS'($urandom_range(15)));
	endtask

	task automatic test_random_traffic(input int phases);
		int ph, n, i;
		logic [CFG_W-1:0] setting;
		logic [ID_BITS-1:0] id;
		for (ph = 0; ph < phases; ph++) begin
			case (ph)
				0: setting = 4'd3;
				1: setting = 4'd8;
				2: setting = 4'd15;
				3: setting = 4'd1;
				default: setting = CFG_W'($urandom_range(15));
			endcase
			write_slots_in_use(setting);
			quiet = (ph == 2);
			for (i = 0; i < POOL_SIZE; i++)
				page_pool[i] = ID_BITS'($urandom);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 80)
					id = page_pool[$urandom_range(POOL_SIZE - 1)];
				else
					id = ID_BITS'($urandom);
				send_access(1'($urandom_range(1)), id);
			end
			quiet = 1'b0;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
		end
	endfunction

	always @(posedge clk) begin : result_check
		access_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result item with none expected, expected nothing actual tdata=%h tuser=%b",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				e = pending_results.pop_front();
				check_field("hit",        e.hit,     m_axis_tuser[TU_HIT]);
				check_field("fill",       e.fill,    m_axis_tuser[TU_FILL]);
				check_field("writeback",  e.wb,      m_axis_tuser[TU_WB]);
				check_field("slot",       e.slot,    m_axis_tdata[SLOT_W-1:0]);
				check_field("evicted_id", e.evicted, m_axis_tdata[SLOT_W +: ID_BITS]);
			end
		end
	end

	always @(negedge clk) begin : result_sink
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= quiet || ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_single_slot();
		test_oversized_setting();
		test_setting_below_occupancy();
		test_output_backpressure();
		test_random_traffic(6);
		wait_idle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
